// ===== rtl/cts_pkg.sv =====
// Shared types and constants of the CIF/STAR token scanner.
// Holds the classified character record, the result record and the token kind codes.
// Depends on nothing; every other file of the block imports it.
package cts_pkg;

   // Depths of the two queues that part the handshakes from the scanner.
   localparam int unsigned REQ_QUEUE_DEPTH = 4;
   localparam int unsigned RSP_QUEUE_DEPTH = 4;

   localparam logic [23:0] LEN_MAX = 24'hFF_FFFF;

   // Token kinds as they appear on the result channel.
   localparam logic [3:0] KIND_DATA     = 4'd0;
   localparam logic [3:0] KIND_LOOP     = 4'd1;
   localparam logic [3:0] KIND_ITEM     = 4'd2;
   localparam logic [3:0] KIND_CATEGORY = 4'd3;
   localparam logic [3:0] KIND_COLUMN   = 4'd4;
   localparam logic [3:0] KIND_SQ       = 4'd5;
   localparam logic [3:0] KIND_DQ       = 4'd6;
   localparam logic [3:0] KIND_COMMENT  = 4'd7;
   localparam logic [3:0] KIND_WORD     = 4'd8;
   localparam logic [3:0] KIND_MISSING  = 4'd9;
   localparam logic [3:0] KIND_TEXT     = 4'd10;
   localparam logic [3:0] KIND_BINARY   = 4'd11;
   localparam logic [3:0] KIND_UNKNOWN  = 4'd12;
   localparam logic [3:0] KIND_END      = 4'd13;

   // Character codes the scanner looks for.
   localparam logic [7:0] CH_TAB      = 8'd9;
   localparam logic [7:0] CH_NL       = 8'd10;
   localparam logic [7:0] CH_CR       = 8'd13;
   localparam logic [7:0] CH_SPACE    = 8'd32;
   localparam logic [7:0] CH_DQUOTE   = 8'd34;
   localparam logic [7:0] CH_HASH     = 8'd35;
   localparam logic [7:0] CH_SQUOTE   = 8'd39;
   localparam logic [7:0] CH_DOT      = 8'd46;
   localparam logic [7:0] CH_SEMI     = 8'd59;
   localparam logic [7:0] CH_QUESTION = 8'd63;
   localparam logic [7:0] CH_UNDER    = 8'd95;
   localparam logic [7:0] CH_TILDE    = 8'd126;
   localparam logic [7:0] CH_LOWER_A  = 8'd97;
   localparam logic [7:0] CH_LOWER_Z  = 8'd122;
   localparam logic [7:0] CH_SUB      = 8'd26;
   localparam logic [7:0] CH_EOT      = 8'd4;
   localparam logic [7:0] CH_BIN_MARK = 8'd213;

   // One character after classification by the front end.
   typedef struct packed {
      logic [7:0] character;
      logic [7:0] upper;
      logic       end_of_stream;
      logic       is_space;
      logic       is_print;
   } item_type;

   // One token report.
   typedef struct packed {
      logic [3:0]  token_kind;
      logic [31:0] text_start;
      logic [23:0] text_length;
      logic        last_result;
   } result_type;

endpackage

// ===== rtl/cts_front.sv =====
// Front end of the token scanner: takes characters, classifies them and queues them.
// Uses item_type and the character codes of cts_pkg.
// Feeds cts_back through a short queue so each side can stall on its own.
module cts_front
   import cts_pkg::*;
#(
   parameter int unsigned DEPTH = REQ_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_character,
   input  logic       req_end_of_stream,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   item_type           classified;
   logic               push;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      classified.character     = req_character;
      classified.end_of_stream = req_end_of_stream;
      classified.is_space      = (req_character == CH_SPACE) ||
                                 (req_character >= CH_TAB && req_character <= CH_CR);
      classified.is_print      = (req_character >= CH_TAB && req_character <= CH_CR) ||
                                 (req_character >= CH_SPACE && req_character <= CH_TILDE);
      if (req_character >= CH_LOWER_A && req_character <= CH_LOWER_Z) begin
         classified.upper = req_character - 8'd32;
      end else begin
         classified.upper = req_character;
      end
   end

   assign req_stall  = (count_ff == CNT_W'(DEPTH));
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = item_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== rtl/cts_back.sv =====
// Back end of the token scanner: the lexer state and the parallel token candidates.
// Uses item_type, result_type, the kind codes and character codes of cts_pkg.
// If rsp_room, takes one classified character per cycle; pushes up to two results.
module cts_back
   import cts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   input  logic       rsp_room,
   output logic [1:0] push_cnt,
   output result_type push0,
   output result_type push1
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SCAN,
      PH_TEXT,
      PH_MARK,
      PH_BIN
   } phase_type;

   localparam int unsigned F_DATA    = 0;
   localparam int unsigned F_LOOP    = 1;
   localparam int unsigned F_ITEM    = 2;
   localparam int unsigned F_COLUMN  = 3;
   localparam int unsigned F_STRING  = 4;
   localparam int unsigned F_COMMENT = 5;
   localparam int unsigned F_WORD    = 6;
   localparam logic [6:0] F_ALL = 7'h7F;

   phase_type   phase_ff, phase_in;
   logic [6:0]  flags_ff, flags_in;
   logic [23:0] len_ff, len_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] pos_ff, pos_in;
   logic        ls_ff, ls_in;
   logic        oqd_ff, oqd_in;
   logic        fwq_ff, fwq_in;

   // Candidate evaluation of the scan phase.
   logic [6:0]  sf;
   logic        sdone;
   logic        sc_emit, sc_idle, sc_col;
   logic [3:0]  sc_kind;
   logic [31:0] sc_start;
   logic [23:0] sc_len;
   logic        stop, is_eos, is_dot, is_nl, is_quote;

   logic        e_valid;
   logic [3:0]  e_kind;
   logic [31:0] e_start;
   logic [23:0] e_len;
   logic        do_mark;
   logic [6:0]  idle_flags;
   result_type  end_res;

   function automatic logic [7:0] data_mark(input logic [2:0] i);
      case (i)
         3'd0:    return 8'h44;
         3'd1:    return 8'h41;
         3'd2:    return 8'h54;
         3'd3:    return 8'h41;
         3'd4:    return 8'h5F;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] loop_mark(input logic [2:0] i);
      case (i)
         3'd0:    return 8'h4C;
         3'd1:    return 8'h4F;
         3'd2:    return 8'h4F;
         3'd3:    return 8'h50;
         3'd4:    return 8'h5F;
         default: return 8'h00;
      endcase
   endfunction

   // Reported length: the saturated value stays at the maximum.
   function automatic logic [23:0] rep_len(input logic [23:0] n, input logic [2:0] off);
      if (n == LEN_MAX) begin
         return LEN_MAX;
      end
      return (n >= 24'(off)) ? n - 24'(off) : '0;
   endfunction

   function automatic logic [23:0] bump(input logic [23:0] n);
      return (n == LEN_MAX) ? n : n + 24'd1;
   endfunction

   assign item_pop = item_valid && rsp_room;
   assign is_eos   = item.end_of_stream;
   assign stop     = item.is_space || is_eos;
   assign is_dot   = !is_eos && (item.character == CH_DOT);
   assign is_nl    = !is_eos && (item.character == CH_NL);
   assign is_quote = !is_eos && (item.character == (oqd_ff ? CH_DQUOTE : CH_SQUOTE));

   always_comb begin
      sf       = flags_ff;
      sdone    = 1'b0;
      sc_emit  = 1'b0;
      sc_idle  = 1'b0;
      sc_col   = 1'b0;
      sc_kind  = KIND_WORD;
      sc_start = start_ff;
      sc_len   = '0;
      if (sf[F_DATA]) begin
         if (len_ff < 24'd5) begin
            if (is_eos || item.upper != data_mark(len_ff[2:0])) begin
               sf[F_DATA] = 1'b0;
            end
         end else if (stop) begin
            sc_emit  = 1'b1;
            sc_kind  = KIND_DATA;
            sc_start = start_ff + 32'd5;
            sc_len   = rep_len(len_ff, 3'd5);
            sc_idle  = 1'b1;
            sdone    = 1'b1;
         end
      end
      if (!sdone && sf[F_LOOP]) begin
         if (len_ff >= 24'd5 || is_eos || item.upper != loop_mark(len_ff[2:0])) begin
            sf[F_LOOP] = 1'b0;
         end else if (len_ff == 24'd4) begin
            sc_emit  = 1'b1;
            sc_kind  = KIND_LOOP;
            sc_start = pos_ff + 32'd1;
            sc_len   = '0;
            sc_idle  = 1'b1;
            sdone    = 1'b1;
         end
      end
      if (!sdone && sf[F_ITEM] && (stop || is_dot)) begin
         sf[F_ITEM] = 1'b0;
         if (len_ff >= 24'd2) begin
            sc_emit  = 1'b1;
            sc_kind  = is_dot ? KIND_CATEGORY : KIND_ITEM;
            sc_start = start_ff + 32'd1;
            sc_len   = rep_len(len_ff, 3'd1);
            sc_col   = is_dot;
            sc_idle  = !is_dot;
            sdone    = 1'b1;
         end
      end
      if (!sdone && sf[F_COLUMN] && stop) begin
         sc_emit  = 1'b1;
         sc_kind  = KIND_COLUMN;
         sc_start = start_ff + 32'd1;
         sc_len   = rep_len(len_ff, 3'd1);
         sc_idle  = 1'b1;
         sdone    = 1'b1;
      end
      if (!sdone && sf[F_STRING] && (is_quote || is_nl || is_eos)) begin
         sc_emit  = 1'b1;
         sc_kind  = oqd_ff ? KIND_DQ : KIND_SQ;
         sc_start = start_ff + 32'd1;
         sc_len   = rep_len(len_ff, 3'd1);
         sc_idle  = 1'b1;
         sdone    = 1'b1;
      end
      if (!sdone && sf[F_COMMENT] && (is_nl || is_eos)) begin
         sc_emit  = 1'b1;
         sc_kind  = KIND_COMMENT;
         sc_start = start_ff + 32'd1;
         sc_len   = rep_len(len_ff, 3'd1);
         sc_idle  = 1'b1;
         sdone    = 1'b1;
      end
      if (!sdone && sf[5:0] == 6'd0) begin
         // Nothing more specific survives, so the token is a plain word.
         sf[F_WORD] = 1'b1;
         if (stop) begin
            sc_emit = 1'b1;
            if (len_ff == 24'd1 && fwq_ff) begin
               sc_kind = KIND_MISSING;
               sc_len  = '0;
            end else begin
               sc_kind = KIND_WORD;
               sc_len  = rep_len(len_ff, 3'd0);
            end
            sc_start = start_ff;
            sc_idle  = 1'b1;
         end
      end
   end

   always_comb begin
      idle_flags = '0;
      if (item.upper == 8'h44) begin
         idle_flags[F_DATA] = 1'b1;
      end
      if (item.upper == 8'h4C) begin
         idle_flags[F_LOOP] = 1'b1;
      end
      if (item.character == CH_UNDER) begin
         idle_flags[F_ITEM] = 1'b1;
      end
      if (item.character == CH_SQUOTE || item.character == CH_DQUOTE) begin
         idle_flags[F_STRING] = 1'b1;
      end
      if (item.character == CH_HASH) begin
         idle_flags[F_COMMENT] = 1'b1;
      end
      if (idle_flags == '0) begin
         idle_flags[F_WORD] = 1'b1;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      flags_in = flags_ff;
      len_in   = len_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      ls_in    = ls_ff;
      oqd_in   = oqd_ff;
      fwq_in   = fwq_ff;
      e_valid  = 1'b0;
      e_kind   = KIND_UNKNOWN;
      e_start  = start_ff;
      e_len    = '0;
      do_mark  = 1'b0;
      if (is_eos) begin
         if (phase_ff == PH_SCAN) begin
            e_valid = sc_emit;
            e_kind  = sc_kind;
            e_start = sc_start;
            e_len   = sc_len;
         end else if (phase_ff == PH_TEXT || phase_ff == PH_MARK || phase_ff == PH_BIN) begin
            e_valid = 1'b1;
            e_kind  = KIND_UNKNOWN;
            e_start = start_ff;
            e_len   = rep_len(len_ff, 3'd0);
         end
         phase_in = PH_IDLE;
         flags_in = F_ALL;
         len_in   = '0;
         start_in = '0;
         pos_in   = '0;
         ls_in    = 1'b1;
         oqd_in   = 1'b0;
         fwq_in   = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!item.is_space) begin
                  start_in = pos_ff;
                  len_in   = 24'd1;
                  if (ls_ff && item.character == CH_SEMI) begin
                     phase_in = PH_TEXT;
                  end else begin
                     flags_in = idle_flags;
                     oqd_in   = (item.character == CH_DQUOTE);
                     fwq_in   = (item.character == CH_QUESTION);
                     phase_in = PH_SCAN;
                  end
               end
            end
            PH_SCAN: begin
               e_valid = sc_emit;
               e_kind  = sc_kind;
               e_start = sc_start;
               e_len   = sc_len;
               if (sc_idle) begin
                  phase_in = PH_IDLE;
                  flags_in = F_ALL;
                  len_in   = '0;
               end else if (sc_col) begin
                  phase_in = PH_SCAN;
                  flags_in = 7'(1 << F_COLUMN);
                  start_in = pos_ff;
                  len_in   = 24'd1;
                  oqd_in   = 1'b0;
                  fwq_in   = 1'b0;
               end else begin
                  flags_in = sf;
                  len_in   = bump(len_ff);
               end
            end
            PH_TEXT: begin
               if (!item.is_print) begin
                  do_mark = 1'b1;
               end else if (item.character == CH_SEMI && ls_ff) begin
                  e_valid  = 1'b1;
                  e_kind   = KIND_TEXT;
                  e_start  = start_ff + 32'd1;
                  e_len    = rep_len(len_ff, 3'd2);
                  phase_in = PH_IDLE;
                  flags_in = F_ALL;
                  len_in   = '0;
               end else begin
                  len_in = bump(len_ff);
               end
            end
            PH_MARK: begin
               do_mark = 1'b1;
            end
            PH_BIN: begin
               if (item.character == CH_SEMI && ls_ff) begin
                  e_valid  = 1'b1;
                  e_kind   = KIND_BINARY;
                  e_start  = start_ff;
                  e_len    = rep_len(len_ff, 3'd0);
                  phase_in = PH_IDLE;
                  flags_in = F_ALL;
                  len_in   = '0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               flags_in = F_ALL;
               len_in   = '0;
            end
         endcase
         // A non-printable byte inside a text field decides between
         // skipping, a binary section and an unknown token.
         if (do_mark) begin
            if (item.character == CH_SUB || item.character == CH_EOT) begin
               phase_in = PH_MARK;
            end else if (item.character == CH_BIN_MARK) begin
               phase_in = PH_BIN;
            end else begin
               e_valid = 1'b1;
               e_kind  = KIND_UNKNOWN;
               e_start = start_ff;
               e_len   = rep_len(len_ff, 3'd0);
               if (item.character == CH_DOT || item.character == CH_HASH) begin
                  phase_in = PH_SCAN;
                  flags_in = 7'(1 << F_COLUMN);
                  start_in = pos_ff;
                  len_in   = 24'd1;
                  oqd_in   = 1'b0;
                  fwq_in   = 1'b0;
               end else begin
                  phase_in = PH_IDLE;
                  flags_in = F_ALL;
                  len_in   = '0;
               end
            end
         end
         pos_in = pos_ff + 32'd1;
         ls_in  = (item.character == CH_NL);
      end
   end

   always_comb begin
      end_res.token_kind  = KIND_END;
      end_res.text_start  = pos_ff;
      end_res.text_length = '0;
      end_res.last_result = 1'b1;
      push0.token_kind    = e_kind;
      push0.text_start    = e_start;
      push0.text_length   = e_len;
      push0.last_result   = !is_eos;
      push1               = end_res;
      push_cnt            = 2'd0;
      if (item_pop) begin
         if (is_eos) begin
            if (e_valid) begin
               push_cnt = 2'd2;
            end else begin
               push0    = end_res;
               push_cnt = 2'd1;
            end
         end else if (e_valid) begin
            push_cnt = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         flags_ff <= F_ALL;
         len_ff   <= '0;
         start_ff <= '0;
         pos_ff   <= '0;
         ls_ff    <= 1'b1;
         oqd_ff   <= 1'b0;
         fwq_ff   <= 1'b0;
      end else if (item_pop) begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         len_ff   <= len_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         ls_ff    <= ls_in;
         oqd_ff   <= oqd_in;
         fwq_ff   <= fwq_in;
      end
   end

   a_push_needs_pop : assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> item_pop)
      else $error("results pushed without a character taken");

   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      (push_cnt == 2'd2) |-> (!push0.last_result && push1.last_result &&
                              push1.token_kind == KIND_END))
      else $error("two results must end with the end token marked last");

   a_eos_restart : assert property (@(posedge clock) disable iff (reset)
      (item_pop && is_eos) |=> (pos_ff == '0 && phase_ff == PH_IDLE && ls_ff))
      else $error("end of stream did not restart the scanner");

endmodule

// ===== rtl/cts_rsp_queue.sv =====
// Result queue of the token scanner: takes up to two results a cycle, hands out one.
// Uses result_type from cts_pkg; filled by cts_back.
// Signals room while two more entries fit.
module cts_rsp_queue
   import cts_pkg::*;
#(
   parameter int unsigned DEPTH = RSP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  push_cnt,
   input  result_type  push0,
   input  result_type  push1,
   output logic        rsp_room,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [31:0] rsp_text_start,
   output logic [23:0] rsp_text_length,
   output logic        rsp_last_result
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;
   logic               pop;
   result_type         head;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign wr_next  = ptr_inc(wr_ptr_ff);
   assign rsp_room = (count_ff <= CNT_W'(DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign pop      = rsp_valid && !rsp_stall;
   assign head     = slot_ff[rd_ptr_ff];

   assign rsp_token_kind  = head.token_kind;
   assign rsp_text_start  = head.text_start;
   assign rsp_text_length = head.text_length;
   assign rsp_last_result = head.last_result;

   always_comb begin
      case (push_cnt)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         slot_ff[wr_next] <= push1;
      end
   end

   a_no_overfill : assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> rsp_room)
      else $error("results pushed into a queue without room");

   a_drain_step : assert property (@(posedge clock) disable iff (reset)
      (pop && push_cnt == 2'd0) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("queue count lost track of a transfer");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(head)))
      else $error("stalled result changed or vanished");

endmodule

// ===== rtl/cif_token_scanner.sv =====
// Top level of the CIF/STAR token scanner.
// Instantiates cts_front, cts_back and cts_rsp_queue; uses cts_pkg.
// Characters enter on req_, token reports leave on rsp_.
//
// The scanner lexes a CIF/STAR text stream fed one byte per req transfer and
// reports each token on the rsp channel by kind, stream position of its text
// and text length; it copies no text. It takes one character per cycle while
// the result queue has room: each byte makes one update of the scanner's
// candidate flags and counters, so the rate is set by that update and by
// the queue's room, checked for two entries before a character is taken.
// A character is registered in the character queue, its results in the
// result queue. Most characters cause no result, a token's closing
// character causes one, and an end-of-stream mark causes the pending token
// (if any) and then the end token, with rsp_last_result set on the final
// result of each character. After the end-of-stream mark the scanner is back
// in its reset state and the next byte starts a new stream at position zero.
// A character queue on the input side and a result queue on the output side
// let req_ and rsp_ stall independently of each other.
module cif_token_scanner
   import cts_pkg::*;
#(
   parameter int unsigned REQ_DEPTH = REQ_QUEUE_DEPTH,
   parameter int unsigned RSP_DEPTH = RSP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [31:0] rsp_text_start,
   output logic [23:0] rsp_text_length,
   output logic        rsp_last_result
);

   item_type   item;
   logic       item_valid;
   logic       item_pop;
   logic       rsp_room;
   logic [1:0] push_cnt;
   result_type push0;
   result_type push1;

   // Classification and the character queue.
   cts_front #(
      .DEPTH(REQ_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_character     (req_character),
      .req_end_of_stream (req_end_of_stream),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop)
   );

   // The lexer itself: one character per cycle while the result queue has room.
   cts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_room   (rsp_room),
      .push_cnt   (push_cnt),
      .push0      (push0),
      .push1      (push1)
   );

   // Results wait here until the rsp side takes them, one transfer per cycle.
   cts_rsp_queue #(
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock           (clock),
      .reset           (reset),
      .push_cnt        (push_cnt),
      .push0           (push0),
      .push1           (push1),
      .rsp_room        (rsp_room),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_text_start  (rsp_text_start),
      .rsp_text_length (rsp_text_length),
      .rsp_last_result (rsp_last_result)
   );

endmodule
